>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the button gesture detector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is asserted.
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, cond, cons, msg) \
	`ASSERT_PROP(label, (cond) |-> (cons), msg)

// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
	`ASSERT_PROP(label, (cond) |=> (cons), msg)

`endif

>>> hw/rtl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants shared by the button gesture detector modules.
// ----------------------------------------------------------------------------
package bgd_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned EV_W       = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd3;

	// Register reset values
	localparam logic                  RST_ACTIVE_LOW   = 1'b1;
	localparam logic [CFG_DATA_W-1:0] RST_PRESS_TICKS  = 16'd500;
	localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE     = 16'd50;
	localparam logic [CFG_DATA_W-1:0] RST_DOUBLE_CLICK = 16'd300;

	// Gesture codes
	localparam logic [EV_W-1:0] EV_IDLE   = 3'd0;
	localparam logic [EV_W-1:0] EV_CLICK  = 3'd1;
	localparam logic [EV_W-1:0] EV_DOUBLE = 3'd2;
	localparam logic [EV_W-1:0] EV_PRESS  = 3'd3;
	localparam logic [EV_W-1:0] EV_HOLD   = 3'd4;

	typedef struct packed {
		logic                  active_low;
		logic [CFG_DATA_W-1:0] press_ticks;
		logic [CFG_DATA_W-1:0] debounce_ticks;
		logic [CFG_DATA_W-1:0] double_click_ticks;
	} cfg_t;

	typedef struct packed {
		logic [EV_W-1:0] event_state;
		logic            stable_level;
		logic            awaiting_second;
	} res_t;

endpackage

>>> hw/rtl/bgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bgd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bgd_pkg::cfg_t                   cfg
);
	import bgd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low         <= RST_ACTIVE_LOW;
			cfg_q.press_ticks        <= RST_PRESS_TICKS;
			cfg_q.debounce_ticks     <= RST_DEBOUNCE;
			cfg_q.double_click_ticks <= RST_DOUBLE_CLICK;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACTIVE_LOW:   cfg_q.active_low         <= cfg_data[0];
				REG_PRESS_TICKS:  cfg_q.press_ticks        <= cfg_data;
				REG_DEBOUNCE:     cfg_q.debounce_ticks     <= cfg_data;
				REG_DOUBLE_CLICK: cfg_q.double_click_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/bgd_core.sv
// ----------------------------------------------------------------------------
// bgd_core
// Gesture state and the single-pass update for one registered sample.
// ----------------------------------------------------------------------------
module bgd_core #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bgd_pkg::cfg_t cfg,
	input  logic          adv,
	input  logic          level,
	input  logic          ack,
	output bgd_pkg::res_t res
);
	import bgd_pkg::*;

	localparam int unsigned TW = TIME_WIDTH;

	logic [TW-1:0]   tick_q, last_change_q, last_press_q, last_click_q;
	logic            deb_q, hold_seen_q, second_q;
	logic [EV_W-1:0] gesture_q;

	logic [TW-1:0]   last_change_n, last_press_n, last_click_n;
	logic            deb_n, hold_seen_n, second_n;
	logic [EV_W-1:0] gesture_n;

	logic [TW-1:0]   since_chg, since_press, since_click;
	logic [TW-1:0]   since_press_n, since_click_n;
	logic [TW-1:0]   press_lim, deb_lim, dbl_lim;
	logic            pressed, accepted, short_rel, in_window, click_set;

	assign press_lim   = TW'(cfg.press_ticks);
	assign deb_lim     = TW'(cfg.debounce_ticks);
	assign dbl_lim     = TW'(cfg.double_click_ticks);

	assign since_chg   = tick_q - last_change_q;
	assign since_press = tick_q - last_press_q;
	assign since_click = tick_q - last_click_q;

	assign pressed   = (level != cfg.active_low);
	assign accepted  = (level != deb_q) && (since_chg > deb_lim);
	assign short_rel = (since_press < press_lim);
	assign in_window = second_q && (since_click < dbl_lim);

	always_comb begin
		last_change_n = last_change_q;
		last_press_n  = last_press_q;
		last_click_n  = last_click_q;
		deb_n         = deb_q;
		hold_seen_n   = hold_seen_q;
		second_n      = second_q;
		click_set     = 1'b0;
		gesture_n     = gesture_q;

		// drop a reported click, double click or press on acknowledge
		if (ack && (gesture_q inside {EV_CLICK, EV_DOUBLE, EV_PRESS}))
			gesture_n = EV_IDLE;

		if (accepted) begin
			deb_n         = level;
			last_change_n = tick_q;
			if (pressed) begin
				last_press_n = tick_q;
				hold_seen_n  = 1'b0;
			end else if (short_rel) begin
				if (in_window) begin
					gesture_n = EV_DOUBLE;
					second_n  = 1'b0;
				end else begin
					second_n     = 1'b1;
					last_click_n = tick_q;
					click_set    = 1'b1;
					gesture_n    = EV_CLICK;
				end
			end else begin
				gesture_n = EV_PRESS;
			end
		end

		// hold test on the raw level against the updated press time
		since_press_n = (accepted && pressed) ? '0 : since_press;
		if (pressed && !hold_seen_n && (since_press_n >= press_lim)) begin
			hold_seen_n = 1'b1;
			gesture_n   = EV_HOLD;
		end

		// close the double click window once it has run out
		since_click_n = click_set ? '0 : since_click;
		if (second_n && (since_click_n > dbl_lim))
			second_n = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			last_change_q <= '0;
			last_press_q  <= '0;
			last_click_q  <= '0;
			deb_q         <= 1'b0;
			hold_seen_q   <= 1'b0;
			second_q      <= 1'b0;
			gesture_q     <= EV_IDLE;
		end else if (adv) begin
			tick_q        <= tick_q + TW'(1);
			last_change_q <= last_change_n;
			last_press_q  <= last_press_n;
			last_click_q  <= last_click_n;
			deb_q         <= deb_n;
			hold_seen_q   <= hold_seen_n;
			second_q      <= second_n;
			gesture_q     <= gesture_n;
		end
	end

	assign res.event_state     = gesture_n;
	assign res.stable_level    = deb_n;
	assign res.awaiting_second = second_n;

endmodule

>>> hw/rtl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// Debounces a sampled button level and reports click, double click, press and
// hold gestures, one result word per sample word.
// ----------------------------------------------------------------------------
// Each input word is one raw button sample taken at a millisecond tick, plus
// an acknowledge bit that clears a reported click, double click or press. The
// block answers every input word with exactly one result word holding the
// gesture code, the debounced level and the double click flag. A word passes
// an input register, is evaluated combinationally against the gesture state,
// and lands in a result register. A new word is taken every cycle unless the
// result register is full and stalled, the rate being set by the state update
// that each sample feeds to the next. The internal tick count advances once
// per word, so time is measured in words, and all time differences wrap at
// 2^TIME_WIDTH. The user must write configuration registers only while no
// word is in flight; the block itself does not enforce this.
module button_gesture_detector #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// sample input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            level,
	input  logic                            ack,
	// result output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bgd_pkg::EV_W-1:0]        event_state,
	output logic                            stable_level,
	output logic                            awaiting_second
);
	import bgd_pkg::*;

	cfg_t cfg;
	res_t res_next;
	res_t res_q;

	logic valid_s1, level_s1, ack_s1;
	logic out_valid_q;
	logic adv;

	bgd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Advance the registered word whenever the result register is free or
	// is being emptied in this cycle.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	// Hold the input only while a word sits in stage one and cannot move on.
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the sample word; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= level;
			ack_s1   <= ack;
		end
	end

	bgd_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv),
		.level  (level_s1),
		.ack    (ack_s1),
		.res    (res_next)
	);

	// Result register: load on advance, drain when taken, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (adv) begin
			res_q <= res_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_state     = res_q.event_state;
	assign stable_level    = res_q.stable_level;
	assign awaiting_second = res_q.awaiting_second;

endmodule

>>> hw/rtl/bgd_checker.sv
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level assertions for the button gesture detector, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            level,
	input logic                            ack,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [bgd_pkg::EV_W-1:0]        event_state,
	input logic                            stable_level,
	input logic                            awaiting_second
);
	import bgd_pkg::*;

	logic [EV_W+1:0] res_bits;
	logic [1:0]      in_bits;
	logic            out_held;
	logic            in_held;
	logic            show_double;

	assign res_bits    = {event_state, stable_level, awaiting_second};
	assign in_bits     = {level, ack};
	assign out_held    = out_valid && out_stall;
	assign in_held     = in_valid && in_stall;
	assign show_double = out_valid && (event_state == EV_DOUBLE);

	// a stalled result word holds
	`ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(res_bits), "stalled result changed")

	// a stalled sample word holds
	`ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(in_bits), "stalled sample changed")

	// input back-pressure only comes from a stalled full result register
	`ASSERT_IMPLIES(a_stall_cause, in_stall, out_held, "input stalled with output free")

	// a double click always closes the window for another
	`ASSERT_IMPLIES(a_double_closes, show_double, !awaiting_second, "double click, window open")

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (.*);
